/* rtl/core/clp_pkg.sv */
`timescale 1ns / 1ps

package clp_pkg;

   // Only the first 22 positions of a line are ever examined.
   localparam int HEAD_LEN = 22;

   typedef logic [7:0] byte_type;
   typedef byte_type [HEAD_LEN-1:0] head_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_RTC  = 2'd1,
      KIND_NODE = 2'd2
   } kind_type;

   localparam byte_type CHAR_CR    = 8'd13;
   localparam byte_type CHAR_LF    = 8'd10;
   localparam byte_type CHAR_COLON = 8'h3A;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_SLASH = 8'h2F;

   localparam logic [31:0] RTC_TAG  = "RTC=";
   localparam logic [39:0] NODE_TAG = "Node=";

   localparam logic [7:0]  MAX_HOUR   = 8'h23;
   localparam logic [7:0]  MAX_MINUTE = 8'h59;
   localparam logic [7:0]  MAX_SECOND = 8'h59;
   localparam logic [7:0]  MAX_DAY    = 8'h31;
   localparam logic [7:0]  MAX_MONTH  = 8'h12;
   localparam logic [7:0]  MAX_YEAR   = 8'h99;

   localparam logic [15:0] MAX_NODE    = 16'd32;
   localparam logic [15:0] MAX_CHANNEL = 16'd8;
   localparam logic [15:0] MIN_SF      = 16'd7;
   localparam logic [15:0] MAX_SF      = 16'd13;
   localparam logic [15:0] MAX_PERIOD  = 16'd3600;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  hour_bcd;
      logic [6:0]  minute_bcd;
      logic [6:0]  second_bcd;
      logic [5:0]  day_bcd;
      logic [4:0]  month_bcd;
      logic [7:0]  year_bcd;
      logic [4:0]  node_address;
      logic [3:0]  channel_id;
      logic [3:0]  spread_factor;
      logic [11:0] sample_period;
   } result_type;

endpackage

/* rtl/core/clp_line_store.sv */
`timescale 1ns / 1ps

module clp_line_store #(
   parameter int LINE_STORE_DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  clp_pkg::byte_type   rx_byte,
   input  logic                drain,
   output clp_pkg::head_type   head,
   output logic                pending
);
   import clp_pkg::*;

   localparam int IDX_W = $clog2(LINE_STORE_DEPTH);

   logic [IDX_W-1:0] wr_index_ff, wr_index_in;
   logic [IDX_W-1:0] slot;
   head_type         head_ff, head_in;
   logic             pending_ff, pending_in;
   logic             is_term;

   // The index wraps before the write, so the last position is never used.
   assign slot    = (wr_index_ff == IDX_W'(LINE_STORE_DEPTH - 1)) ? '0 : wr_index_ff;
   assign is_term = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

   always_comb begin
      head_in     = head_ff;
      wr_index_in = wr_index_ff;
      pending_in  = pending_ff && !drain;
      if (accept) begin
         for (int k = 0; k < HEAD_LEN; k++) begin
            if (slot == IDX_W'(k)) begin
               head_in[k] = rx_byte;
            end
         end
         wr_index_in = is_term ? '0 : slot + 1'b1;
         if (is_term) begin
            pending_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         wr_index_ff <= '0;
         pending_ff  <= 1'b0;
      end else begin
         head_ff     <= head_in;
         wr_index_ff <= wr_index_in;
         pending_ff  <= pending_in;
      end
   end

   assign head    = head_ff;
   assign pending = pending_ff;

endmodule

/* rtl/core/clp_check.sv */
`timescale 1ns / 1ps

module clp_check (
   input  clp_pkg::head_type   head,
   output clp_pkg::result_type result
);
   import clp_pkg::*;

   function automatic logic [15:0] digit(input byte_type b);
      return {8'd0, b} - 16'd48;
   endfunction

   function automatic logic [7:0] pack_bcd(input byte_type hi, input byte_type lo);
      return {hi[3:0], lo[3:0]};
   endfunction

   logic [7:0]  hour, minute, second, day, month, year;
   logic [15:0] node, node_m1, chan, sf, period;
   logic        rtc_ok, node_ok;

   always_comb begin
      hour   = pack_bcd(head[4],  head[5]);
      minute = pack_bcd(head[7],  head[8]);
      second = pack_bcd(head[10], head[11]);
      day    = pack_bcd(head[13], head[14]);
      month  = pack_bcd(head[16], head[17]);
      year   = pack_bcd(head[19], head[20]);

      rtc_ok = ({head[0], head[1], head[2], head[3]} == RTC_TAG)
               && head[6] == CHAR_COLON && head[9] == CHAR_COLON
               && head[12] == CHAR_SPACE && head[15] == CHAR_SLASH
               && head[18] == CHAR_SLASH && head[21] == CHAR_CR
               && hour <= MAX_HOUR && minute <= MAX_MINUTE
               && second <= MAX_SECOND && day <= MAX_DAY
               && month <= MAX_MONTH && year <= MAX_YEAR;

      // All digit arithmetic wraps at 16 bits.
      node    = 16'(digit(head[5]) * 16'd10) + digit(head[6]);
      node_m1 = node - 16'd1;
      chan    = digit(head[8]);
      sf      = 16'(digit(head[10]) * 16'd10) + digit(head[11]);
      period  = 16'(digit(head[13]) * 16'd1000) + 16'(digit(head[14]) * 16'd100)
                + 16'(digit(head[15]) * 16'd10) + digit(head[16]);

      node_ok = ({head[0], head[1], head[2], head[3], head[4]} == NODE_TAG)
                && head[7] == CHAR_SPACE && head[9] == CHAR_SPACE
                && head[12] == CHAR_SPACE
                && node != 16'd0 && node <= MAX_NODE
                && chan <= MAX_CHANNEL
                && sf >= MIN_SF && sf <= MAX_SF
                && period <= MAX_PERIOD;

      result      = '0;
      result.kind = KIND_NONE;
      if (rtc_ok) begin
         result.kind       = KIND_RTC;
         result.hour_bcd   = hour[5:0];
         result.minute_bcd = minute[6:0];
         result.second_bcd = second[6:0];
         result.day_bcd    = day[5:0];
         result.month_bcd  = month[4:0];
         result.year_bcd   = year;
      end else if (node_ok) begin
         result.kind          = KIND_NODE;
         result.node_address  = node_m1[4:0];
         result.channel_id    = chan[3:0];
         result.spread_factor = sf[3:0];
         result.sample_period = period[11:0];
      end
   end

endmodule

/* rtl/core/clp_rsp_reg.sv */
`timescale 1ns / 1ps

module clp_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  clp_pkg::result_type result_d,
   input  logic                rsp_ready,
   output logic                free,
   output logic                rsp_valid,
   output clp_pkg::result_type result_q
);
   import clp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);
   assign data_in  = load ? result_d : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign result_q  = data_ff;

endmodule

/* rtl/core/serial_command_line_parser.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_rx_byte
// rsp_      out        rsp_valid / rsp_ready  rsp_kind and the ten result fields
//
// One byte transaction is taken per cycle while req_ready is high. A line terminator
// (CR or LF) yields one result transaction: the accepting edge stores the byte and
// marks the line finished; the line is then checked and loaded into the result
// register once that register has room, and offered on rsp_valid.
// Reset is synchronous and active high; it clears the line store and the index.
// A finished line waits in the store only while the result register is full and
// not being taken; in that case, and during reset, req_ready drops.

module serial_command_line_parser #(
   parameter int LINE_STORE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_hour_bcd,
   output logic [6:0]  rsp_minute_bcd,
   output logic [6:0]  rsp_second_bcd,
   output logic [5:0]  rsp_day_bcd,
   output logic [4:0]  rsp_month_bcd,
   output logic [7:0]  rsp_year_bcd,
   output logic [4:0]  rsp_node_address,
   output logic [3:0]  rsp_channel_id,
   output logic [3:0]  rsp_spread_factor,
   output logic [11:0] rsp_sample_period
);
   import clp_pkg::*;

   head_type   head;
   result_type checked;
   result_type held;
   logic       pending;
   logic       free;
   logic       drain;
   logic       accept;

   // A completed line moves into the result register as soon as that register
   // has room. Until it does, the store must not change, so input stalls.
   assign drain     = pending && free;
   assign req_ready = !reset && (!pending || free);
   assign accept    = req_valid && req_ready;

   clp_line_store #(
      .LINE_STORE_DEPTH(LINE_STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .drain   (drain),
      .head    (head),
      .pending (pending)
   );

   // The fixed-position checks read the registered line head directly.
   clp_check u_check (
      .head   (head),
      .result (checked)
   );

   clp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (drain),
      .result_d  (checked),
      .rsp_ready (rsp_ready),
      .free      (free),
      .rsp_valid (rsp_valid),
      .result_q  (held)
   );

   assign rsp_kind          = held.kind;
   assign rsp_hour_bcd      = held.hour_bcd;
   assign rsp_minute_bcd    = held.minute_bcd;
   assign rsp_second_bcd    = held.second_bcd;
   assign rsp_day_bcd       = held.day_bcd;
   assign rsp_month_bcd     = held.month_bcd;
   assign rsp_year_bcd      = held.year_bcd;
   assign rsp_node_address  = held.node_address;
   assign rsp_channel_id    = held.channel_id;
   assign rsp_spread_factor = held.spread_factor;
   assign rsp_sample_period = held.sample_period;

endmodule

/* rtl/core/clp_checker.sv */
`timescale 1ns / 1ps

module clp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [5:0]  rsp_hour_bcd,
   input logic [6:0]  rsp_minute_bcd,
   input logic [6:0]  rsp_second_bcd,
   input logic [5:0]  rsp_day_bcd,
   input logic [4:0]  rsp_month_bcd,
   input logic [7:0]  rsp_year_bcd,
   input logic [4:0]  rsp_node_address,
   input logic [3:0]  rsp_channel_id,
   input logic [3:0]  rsp_spread_factor,
   input logic [11:0] rsp_sample_period
);
   import clp_pkg::*;

   logic term_acc;
   assign term_acc = req_valid && req_ready
                     && (req_rx_byte == CHAR_CR || req_rx_byte == CHAR_LF);

   // A stalled result transaction keeps its kind.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result changed while stalled");

   // Results appear only after a line terminator was taken.
   a_cause : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !term_acc && !$past(term_acc) |=> !rsp_valid)
      else $error("result without a line terminator");

   // A rejected line carries all-zero fields.
   a_reject : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NONE |->
         rsp_hour_bcd == '0 && rsp_minute_bcd == '0 && rsp_second_bcd == '0
         && rsp_day_bcd == '0 && rsp_month_bcd == '0 && rsp_year_bcd == '0
         && rsp_node_address == '0 && rsp_channel_id == '0
         && rsp_spread_factor == '0 && rsp_sample_period == '0)
      else $error("rejected line with non-zero fields");

   // A node configuration keeps channel, spread factor and period within range and leaves hour and year clear.
   a_node : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NODE |->
         rsp_channel_id <= 4'd8 && rsp_spread_factor >= 4'd7
         && rsp_spread_factor <= 4'd13 && rsp_sample_period <= 12'd3600
         && rsp_hour_bcd == '0 && rsp_year_bcd == '0)
      else $error("node configuration out of range");

endmodule

bind serial_command_line_parser clp_checker u_clp_checker (.*);

/* bench/tb_serial_command_line_parser.sv */
`timescale 1ns / 1ps

module tb_serial_command_line_parser;
   import clp_pkg::*;

   localparam int STORE_DEPTH  = 128;
   // The random part stops once this many bytes have been taken by the block.
   localparam int BYTE_TARGET  = 1900;
   // Far above what the slowest correct run needs.
   localparam int CYCLE_LIMIT  = 600000;
   // The long hold-off on the result side, and the result count at which it starts.
   localparam int HOLD_CYCLES  = 700;
   localparam int HOLD_AT      = 12;
   // Extra wait once every pending result has been checked.
   localparam int DRAIN_CYCLES = 8;

   // The line checker keeps its own copy of the first positions of the line store
   // and the write index, and works out the result of every finished line.
   class line_result_board;
      head_type    head;
      int unsigned store_index;
      result_type  pending_results[$];
      int unsigned lines_seen;
      int unsigned rtc_lines;
      int unsigned node_lines;
      int unsigned results_checked;
      int unsigned mismatches;

      function new();
         head            = '0;
         store_index     = 0;
         lines_seen      = 0;
         rtc_lines       = 0;
         node_lines      = 0;
         results_checked = 0;
         mismatches      = 0;
      endfunction

      // Packed BCD from the low nibbles of two neighbouring positions.
      function logic [7:0] bcd_at(int pos);
         return {head[pos][3:0], head[pos+1][3:0]};
      endfunction

      // Decimal digit value; bytes below '0' wrap round in 16 bits.
      function logic [15:0] digit_at(int pos);
         return {8'h00, head[pos]} - 16'd48;
      endfunction

      function result_type parse_line();
         result_type  r;
         logic [7:0]  hr, mi, sc, dy, mo, yr;
         logic [15:0] node, chan, sf, per;
         r = '0;
         lines_seen++;
         hr = bcd_at(4);
         mi = bcd_at(7);
         sc = bcd_at(10);
         dy = bcd_at(13);
         mo = bcd_at(16);
         yr = bcd_at(19);
         // A date line needs every separator in place and CR exactly at the end.
         if ({head[0], head[1], head[2], head[3]} == RTC_TAG &&
             head[6] == CHAR_COLON && head[9] == CHAR_COLON && head[12] == CHAR_SPACE &&
             head[15] == CHAR_SLASH && head[18] == CHAR_SLASH && head[21] == CHAR_CR &&
             hr <= MAX_HOUR && mi <= MAX_MINUTE && sc <= MAX_SECOND &&
             dy <= MAX_DAY && mo <= MAX_MONTH && yr <= MAX_YEAR) begin
            r.kind       = KIND_RTC;
            r.hour_bcd   = hr[5:0];
            r.minute_bcd = mi[6:0];
            r.second_bcd = sc[6:0];
            r.day_bcd    = dy[5:0];
            r.month_bcd  = mo[4:0];
            r.year_bcd   = yr;
            rtc_lines++;
            return r;
         end
         // The sums are kept in 16 bits, so odd bytes may still give legal numbers.
         node = digit_at(5) * 16'd10 + digit_at(6);
         chan = digit_at(8);
         sf   = digit_at(10) * 16'd10 + digit_at(11);
         per  = digit_at(13) * 16'd1000 + digit_at(14) * 16'd100 +
                digit_at(15) * 16'd10 + digit_at(16);
         if ({head[0], head[1], head[2], head[3], head[4]} == NODE_TAG &&
             head[7] == CHAR_SPACE && head[9] == CHAR_SPACE && head[12] == CHAR_SPACE &&
             node >= 16'd1 && node <= MAX_NODE && chan <= MAX_CHANNEL &&
             sf >= MIN_SF && sf <= MAX_SF && per <= MAX_PERIOD) begin
            r.kind          = KIND_NODE;
            r.node_address  = node[4:0] - 5'd1;
            r.channel_id    = chan[3:0];
            r.spread_factor = sf[3:0];
            r.sample_period = per[11:0];
            node_lines++;
         end
         return r;
      endfunction

      // Called for every accepted byte transaction.
      function void take_byte(logic [7:0] rx);
         if (store_index >= STORE_DEPTH - 1) store_index = 0;
         if (store_index < HEAD_LEN) head[store_index] = rx;
         store_index++;
         if (rx == CHAR_CR || rx == CHAR_LF) begin
            store_index = 0;
            pending_results.push_back(parse_line());
         end
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function string describe(result_type r);
         return $sformatf("kind %0d time %h:%h:%h date %h/%h/%h node %0d ch %0d sf %0d per %0d",
                          r.kind, r.hour_bcd, r.minute_bcd, r.second_bcd, r.day_bcd,
                          r.month_bcd, r.year_bcd, r.node_address, r.channel_id,
                          r.spread_factor, r.sample_period);
      endfunction

      // Called for every accepted result transaction.
      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result transaction with no line pending: %s", describe(got));
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (got.kind !== want.kind || got.hour_bcd !== want.hour_bcd ||
             got.minute_bcd !== want.minute_bcd || got.second_bcd !== want.second_bcd ||
             got.day_bcd !== want.day_bcd || got.month_bcd !== want.month_bcd ||
             got.year_bcd !== want.year_bcd || got.node_address !== want.node_address ||
             got.channel_id !== want.channel_id || got.spread_factor !== want.spread_factor ||
             got.sample_period !== want.sample_period) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d differs", results_checked);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [1:0]  rsp_kind;
   logic [5:0]  rsp_hour_bcd;
   logic [6:0]  rsp_minute_bcd;
   logic [6:0]  rsp_second_bcd;
   logic [5:0]  rsp_day_bcd;
   logic [4:0]  rsp_month_bcd;
   logic [7:0]  rsp_year_bcd;
   logic [4:0]  rsp_node_address;
   logic [3:0]  rsp_channel_id;
   logic [3:0]  rsp_spread_factor;
   logic [11:0] rsp_sample_period;

   line_result_board board;

   // Bytes of the line being built, and the running count of accepted bytes.
   logic [7:0]  line_bytes[$];
   int unsigned bytes_sent    = 0;
   bit          sender_steady = 1'b0;

   serial_command_line_parser #(
      .LINE_STORE_DEPTH(STORE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_hour_bcd     (rsp_hour_bcd),
      .rsp_minute_bcd   (rsp_minute_bcd),
      .rsp_second_bcd   (rsp_second_bcd),
      .rsp_day_bcd      (rsp_day_bcd),
      .rsp_month_bcd    (rsp_month_bcd),
      .rsp_year_bcd     (rsp_year_bcd),
      .rsp_node_address (rsp_node_address),
      .rsp_channel_id   (rsp_channel_id),
      .rsp_spread_factor(rsp_spread_factor),
      .rsp_sample_period(rsp_sample_period)
   );

   always #10 clock = ~clock;

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endfunction

   // Pushes a decimal number as a fixed count of ASCII digits, most significant first.
   function automatic void push_number(int unsigned value, int count);
      int unsigned scale;
      scale = 1;
      for (int i = 1; i < count; i++) scale *= 10;
      for (int i = 0; i < count; i++) begin
         line_bytes.push_back(8'd48 + 8'((value / scale) % 10));
         scale /= 10;
      end
   endfunction

   // Any byte other than a line terminator.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   // A date/time command without its terminator. A quarter of them let the time, day and
   // month fields run past their limits.
   task automatic build_date_line();
      bit wide;
      int pos;
      wide = ($urandom_range(0, 3) == 0);
      push_text("RTC=");
      push_number(wide ? $urandom_range(0, 39) : $urandom_range(0, 23), 2);
      line_bytes.push_back(CHAR_COLON);
      push_number(wide ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
      line_bytes.push_back(CHAR_COLON);
      push_number(wide ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
      line_bytes.push_back(CHAR_SPACE);
      push_number(wide ? $urandom_range(0, 49) : $urandom_range(0, 31), 2);
      line_bytes.push_back(CHAR_SLASH);
      push_number(wide ? $urandom_range(0, 19) : $urandom_range(0, 12), 2);
      line_bytes.push_back(CHAR_SLASH);
      push_number($urandom_range(0, 99), 2);
      // Digits are not checked as such: a stray byte counts by its low nibble only.
      if ($urandom_range(0, 7) == 0) begin
         pos = 4 + 3 * $urandom_range(0, 5) + $urandom_range(0, 1);
         line_bytes[pos] = noise_byte();
      end
   endtask

   // A node command without its terminator. Now and then the node number or the
   // spread factor is written as '/' followed by a byte above '9', which the
   // 16-bit digit sum wraps back to the intended value.
   task automatic build_node_line();
      bit wide;
      int unsigned node, sf;
      wide = ($urandom_range(0, 2) == 0);
      push_text("Node=");
      node = wide ? $urandom_range(0, 45) : $urandom_range(1, 32);
      if ($urandom_range(0, 9) == 0) begin
         line_bytes.push_back(CHAR_SLASH);
         line_bytes.push_back(8'd58 + 8'(node));
      end else begin
         push_number(node, 2);
      end
      line_bytes.push_back(CHAR_SPACE);
      push_number(wide ? $urandom_range(0, 9) : $urandom_range(0, 8), 1);
      line_bytes.push_back(CHAR_SPACE);
      sf = wide ? $urandom_range(0, 19) : $urandom_range(7, 13);
      if ($urandom_range(0, 9) == 0) begin
         line_bytes.push_back(CHAR_SLASH);
         line_bytes.push_back(8'd58 + 8'(sf));
      end else begin
         push_number(sf, 2);
      end
      line_bytes.push_back(CHAR_SPACE);
      push_number(wide ? $urandom_range(0, 9999) : $urandom_range(0, 3600), 4);
   endtask

   // Offers one byte transaction. Valid is only lowered when an idle gap is drawn,
   // so consecutive bytes can follow edge to edge.
   task automatic send_item(logic [7:0] rx);
      int gap;
      if ($urandom_range(0, 29) == 0) sender_steady = !sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      board.take_byte(rx);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_item(line_bytes[i]);
      line_bytes.delete();
   endtask

   // Result side. It idles at random between transactions, and once holds off for a
   // long stretch so that a second finished line has to wait and req_ready drops.
   initial begin : result_sink
      result_type got;
      int gap;
      bit steady;
      bit held;
      steady = 1'b0;
      held   = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) steady = !steady;
         gap = steady ? 0 : $urandom_range(0, 14);
         if (!held && board.results_checked == HOLD_AT) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_kind, rsp_hour_bcd, rsp_minute_bcd, rsp_second_bcd, rsp_day_bcd,
                rsp_month_bcd, rsp_year_bcd, rsp_node_address, rsp_channel_id,
                rsp_spread_factor, rsp_sample_period};
         board.check_result(got);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR: run stopped after %0d cycles", CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned choice;
      int unsigned cut;
      bit          is_command;
      logic [7:0]  ending;
      board = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed lines: a bare CR against the cleared store, a date/time command at
      // the upper limit of every field, a node command at its upper limits ended by
      // LF, and the two extreme byte values followed by LF.
      line_bytes.push_back(CHAR_CR);
      push_text("RTC=23:59:59 31/12/99");
      line_bytes.push_back(CHAR_CR);
      push_text("Node=32 8 13 3600");
      line_bytes.push_back(CHAR_LF);
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(CHAR_LF);
      send_line();

      // Random lines, most of them well-formed commands with random content.
      while (bytes_sent < BYTE_TARGET) begin
         choice     = $urandom_range(0, 99);
         is_command = 1'b1;
         if (choice < 4) begin
            // An overlong line. Junk in multiples of the wrap length puts the command
            // that follows back at position zero; other lengths bury it.
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(127, 260)
                                              : (STORE_DEPTH - 1) * $urandom_range(1, 2);
            repeat (cut) line_bytes.push_back(noise_byte());
            build_date_line();
         end else if (choice < 42) begin
            build_date_line();
         end else if (choice < 82) begin
            build_node_line();
         end else begin
            repeat ($urandom_range(0, 30)) line_bytes.push_back(noise_byte());
            is_command = 1'b0;
         end
         if (is_command && $urandom_range(0, 4) == 0)
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         // Cutting a command short leaves the tail of the previous line in the store;
         // a cut just before the end can meet a stale CR at the last checked position.
         if (is_command && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, 1) ? line_bytes.size() - 1 - $urandom_range(0, 1)
                                       : $urandom_range(0, line_bytes.size() - 1);
            while (line_bytes.size() > cut) void'(line_bytes.pop_back());
         end
         if (choice < 42)
            ending = ($urandom_range(0, 7) == 0) ? CHAR_LF : CHAR_CR;
         else
            ending = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
         line_bytes.push_back(ending);
         send_line();
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes forming %0d lines; %0d results checked.",
               bytes_sent, board.lines_seen, board.results_checked);
      $display("Accepted %0d date/time and %0d node commands; %0d mismatches.",
               board.rtc_lines, board.node_lines, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/clp_pkg.sv
rtl/core/clp_line_store.sv
rtl/core/clp_check.sv
rtl/core/clp_rsp_reg.sv
rtl/core/serial_command_line_parser.sv
rtl/core/clp_checker.sv
bench/tb_serial_command_line_parser.sv
